FILE: hdl/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

    // default configuration of the block
    localparam int MAX_SHIFT_DEF = 15;
    localparam int MAX_WIDTH_DEF = 4096;

    // pixel byte layout
    localparam int DEPTH_W = 8;
    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;

    // APB register map
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int ROW_WIDTH_W   = 13;
    localparam int ROW_WIDTH_RST = 640;
    localparam logic [APB_ADDR_W-3:0] REG_ROW_WIDTH = '0;

    // blue, green and red of one pixel
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

endpackage

`default_nettype wire

FILE: hdl/dsa_depth_shift.sv
`default_nettype none

// shift = MAX_SHIFT * depth / 255, integer quotient.
// Divide by 255 done as q = (y + (y >> 8)) >> 8 with y = x + 1,
// exact for x below 65535 (x here is at most MAX_SHIFT * 255).
module dsa_depth_shift #(
    parameter int MAX_SHIFT = dsa_pkg::MAX_SHIFT_DEF
) (
    input  wire logic [dsa_pkg::DEPTH_W-1:0]           i_depth,
    output logic      [$clog2(MAX_SHIFT+1)-1:0]        o_shift
);
    import dsa_pkg::*;

    localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);
    localparam int PROD_W  = SHIFT_W + DEPTH_W;
    localparam int SUM_W   = PROD_W + 2;

    logic [SUM_W-1:0] prod;
    logic [SUM_W-1:0] prod_inc;
    logic [SUM_W-1:0] quot;

    always_comb begin
        prod     = SUM_W'(MAX_SHIFT) * SUM_W'(i_depth);
        prod_inc = prod + SUM_W'(1);
        quot     = (prod_inc + (prod_inc >> 8)) >> 8;
        o_shift  = quot[SHIFT_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hdl/depth_shift_anaglyph_top.sv
// Output: a pixel is loaded into the output register at the edge that accepts the pixel
//   MAX_SHIFT columns to its right, or during the row-end drain, and tvalid is set at that edge.
// Throughput: one pixel per clock in a row while the output is not stalled. The last pixel
//   of a row drains the MAX_SHIFT entry window, pausing while the output stalls, with
//   s_axis_tready low. Inside a row tready follows the output once the window is full.
// Reset: i_rst_n synchronous, active low; clears valid bits, column counter and drain state,
//   row_width returns to 640. Window payload is not cleared.
`default_nettype none

module depth_shift_anaglyph_top #(
    parameter int MAX_SHIFT = dsa_pkg::MAX_SHIFT_DEF,
    parameter int MAX_WIDTH = dsa_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // APB configuration
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [dsa_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  wire logic [dsa_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic      [dsa_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                                 o_pready,
    // pixel in
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [31:0]                     i_s_axis_tdata, // in_blue, in_green, in_red, depth
    // pixel out
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [23:0]                     o_m_axis_tdata, // out_blue, out_green, out_red
    output logic                                 o_m_axis_tlast  // row_last
);
    import dsa_pkg::*;

    localparam int WIN     = MAX_SHIFT;            // window taps; incoming word is the newest
    localparam int TOP     = MAX_SHIFT - 1;        // oldest tap
    localparam int IDX_W   = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW      = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W   = (EW > ROW_WIDTH_W) ? EW : ROW_WIDTH_W;
    localparam int SUM_W   = ((COL_W > SHIFT_W) ? COL_W : SHIFT_W) + 2;

    // ---------------- configuration ----------------
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic                   cfg_wr;
    logic                   cfg_sel;

    assign o_pready = 1'b1;
    assign cfg_sel  = (i_paddr[APB_ADDR_W-1:2] == REG_ROW_WIDTH);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready && cfg_sel;
    assign o_prdata = cfg_sel ? APB_DATA_W'(r_row_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_W'(ROW_WIDTH_RST);
        end else if (cfg_wr) begin
            r_row_width <= i_pwdata[ROW_WIDTH_W-1:0];
        end
    end

    // effective width: zero acts as one, anything above MAX_WIDTH as MAX_WIDTH
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_clamp;
    logic [EW-1:0]    eff_width;

    always_comb begin
        width_ext = CMP_W'(r_row_width);
        if (width_ext == '0) begin
            width_clamp = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_clamp = CMP_W'(MAX_WIDTH);
        end else begin
            width_clamp = width_ext;
        end
        eff_width = width_clamp[EW-1:0];
    end

    // ---------------- input word ----------------
    t_rgb                in_rgb;
    logic [SHIFT_W-1:0]  in_shift;

    assign in_rgb.blue  = i_s_axis_tdata[7:0];
    assign in_rgb.green = i_s_axis_tdata[15:8];
    assign in_rgb.red   = i_s_axis_tdata[23:16];

    // shift is worked out on entry and kept in the window instead of depth
    dsa_depth_shift #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_depth_shift (
        .i_depth (i_s_axis_tdata[31:24]),
        .o_shift (in_shift)
    );

    // ---------------- shift window ----------------
    // Tap 0 holds the pixel before the incoming one, tap TOP the oldest. The window moves
    // one tap per accepted pixel, and with bubbles while a row end drains. A pixel is
    // emitted as it leaves tap TOP; its source pixel then sits at tap TOP - shift, or is
    // the incoming word itself for a full shift.
    t_rgb               r_win_rgb [WIN];
    logic [SHIFT_W-1:0] r_win_m   [WIN];
    logic [COL_W-1:0]   r_win_col [WIN];
    logic [WIN-1:0]     r_win_last;
    logic [WIN-1:0]     r_vld;
    logic [WIN-1:0]     n_vld;

    logic [COL_W-1:0]   r_col;      // column of the next incoming pixel
    logic               r_flush;    // row end drain in progress
    logic               n_flush;

    logic               out_free;
    logic               adv_ok;
    logic               s_acc;
    logic               advance;
    logic               emit;
    logic               in_last;

    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign adv_ok          = out_free || !r_vld[TOP];
    assign o_s_axis_tready = !r_flush && adv_ok;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign advance         = s_acc || (r_flush && adv_ok);
    assign emit            = advance && r_vld[TOP];
    assign in_last         = (EW'(r_col) + EW'(1)) >= eff_width;

    always_comb begin
        n_vld   = r_vld;
        n_flush = r_flush;
        if (advance) begin
            n_vld = {r_vld[WIN-2:0], s_acc};
        end
        if (s_acc && in_last) begin
            n_flush = 1'b1;
        end else if (r_flush) begin
            n_flush = |n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_flush <= 1'b0;
            r_col   <= '0;
        end else begin
            r_vld   <= n_vld;
            r_flush <= n_flush;
            if (s_acc) begin
                r_col <= in_last ? '0 : r_col + COL_W'(1);
            end
        end
    end

    // window payload, no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_win_rgb[0]  <= in_rgb;
            r_win_m[0]    <= in_shift;
            r_win_col[0]  <= r_col;
            r_win_last[0] <= in_last;
            for (int i = 1; i < WIN; i++) begin
                r_win_rgb[i]  <= r_win_rgb[i-1];
                r_win_m[i]    <= r_win_m[i-1];
                r_win_col[i]  <= r_win_col[i-1];
                r_win_last[i] <= r_win_last[i-1];
            end
        end
    end

    // ---------------- output word ----------------
    logic [IDX_W-1:0]   src_tap;
    t_rgb               src_rgb;
    t_rgb               own_rgb;
    logic [SUM_W-1:0]   src_end;
    logic               take_src;
    t_rgb               out_rgb;

    always_comb begin
        own_rgb  = r_win_rgb[TOP];
        // full shift: source is the word being accepted (never taken while draining)
        src_tap  = '0;
        src_rgb  = in_rgb;
        if (r_win_m[TOP] != SHIFT_W'(MAX_SHIFT)) begin
            src_tap = IDX_W'(SHIFT_W'(TOP) - r_win_m[TOP]);
            src_rgb = r_win_rgb[src_tap];
        end
        src_end  = SUM_W'(r_win_col[TOP]) + SUM_W'(r_win_m[TOP]) + SUM_W'(1);
        take_src = src_end < SUM_W'(eff_width);
        out_rgb  = own_rgb;
        if (take_src) begin
            out_rgb.blue  = src_rgb.blue;
            out_rgb.green = src_rgb.green;
        end
    end

    logic   r_out_vld;
    t_rgb   r_out_rgb;
    logic   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_rgb  <= out_rgb;
            r_out_last <= r_win_last[TOP];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_rgb.red, r_out_rgb.green, r_out_rgb.blue};
    assign o_m_axis_tlast  = r_out_last;

    // ---------------- checks ----------------
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && in_last) |=> r_flush)
        else $error("row end did not start drain");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flush) |-> (r_vld == '0))
        else $error("drain ended with pixels left in window");

    a_one_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld & r_win_last) <= 1)
        else $error("more than one row end in window");

    a_col_zero_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_col == '0))
        else $error("column count not cleared at row end");

endmodule

`default_nettype wire
